// ===== rtl/srtf_pkg.sv =====
// Shared types, constants and codes of the SRTF scheduler.
package srtf_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Item kinds
  localparam logic FUNC_ARRIVE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  // Result marks
  localparam logic [1:0] MARK_IDLE     = 2'd0;
  localparam logic [1:0] MARK_SWITCH   = 2'd1;
  localparam logic [1:0] MARK_CONTINUE = 2'd2;
  localparam logic [1:0] MARK_ARRIVAL  = 2'd3;

  typedef struct packed {
    logic        func;
    logic [7:0]  proc_id;
    logic [15:0] burst;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  mark;
    logic        accepted;
    logic [7:0]  run_id;
    logic        first_start;
    logic [31:0] launch_time;
    logic        completed;
    logic [31:0] finish_time;
  } out_item_t;

  // One waiting-table entry as stored in the slot memory
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] remaining;
    logic [31:0] stamp;
    logic [7:0]  order;
    logic        started;
  } entry_t;

  // Requests from the controller to the table
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             wr_set_valid;
    logic             clr_en;
    logic [IDX_W-1:0] clr_addr;
  } tbl_req_t;

  // Responses from the table to the controller
  typedef struct packed {
    entry_t           rd_data;
    logic             rd_valid;
    logic [IDX_W-1:0] free_idx;
    logic             full;
  } tbl_rsp_t;

endpackage

// ===== rtl/srtf_table.sv =====
// Waiting table: slot memory with registered read, per-slot valid bits, free-slot finder.
module srtf_table (
  input  logic              clk,
  input  logic              rst_n,
  input  srtf_pkg::tbl_req_t req,
  output srtf_pkg::tbl_rsp_t rsp
);

  srtf_pkg::entry_t mem [srtf_pkg::TABLE_DEPTH];
  logic [srtf_pkg::TABLE_DEPTH-1:0] valid_r;
  srtf_pkg::entry_t rd_data_r;
  logic             rd_valid_r;
  logic [srtf_pkg::IDX_W-1:0] free_idx;
  logic                       full;

  // Write and read the slot memory
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r  <= mem[req.rd_addr];
      rd_valid_r <= valid_r[req.rd_addr];
    end
  end

  // Set and clear valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (req.wr_en && req.wr_set_valid) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.clr_en) begin
        valid_r[req.clr_addr] <= 1'b0;
      end
    end
  end

  // Find the lowest free slot
  always_comb begin
    free_idx = '0;
    full     = 1'b1;
    for (int i = srtf_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = srtf_pkg::IDX_W'(i);
        full     = 1'b0;
      end
    end
  end

  assign rsp.rd_data  = rd_data_r;
  assign rsp.rd_valid = rd_valid_r;
  assign rsp.free_idx = free_idx;
  assign rsp.full     = full;

endmodule

// ===== rtl/srtf_ctrl.sv =====
// Scheduler control: arrival insert, table scan for the best entry, preemption decision.
module srtf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  srtf_pkg::in_item_t  in_data,
  input  logic [7:0]          time_unit,
  output logic                res_valid,
  output srtf_pkg::out_item_t res_data,
  input  logic                res_take,
  output srtf_pkg::tbl_req_t  tbl_req,
  input  srtf_pkg::tbl_rsp_t  tbl_rsp
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DECIDE, ST_RESP} state_t;

  state_t                      state_r;
  logic [31:0]                 now_r;
  logic [srtf_pkg::CNT_W-1:0]  cnt_r;
  logic                        pend_r;
  logic [srtf_pkg::IDX_W-1:0]  pidx_r;
  logic                        found_r;
  logic [srtf_pkg::IDX_W-1:0]  best_idx_r;
  srtf_pkg::entry_t            best_r;
  logic [7:0]                  oc_r;
  logic                        run_valid_r;
  logic [7:0]                  run_proc_r;
  logic [15:0]                 run_left_r;
  srtf_pkg::out_item_t         res_r;

  logic                accept;
  logic                arrive;
  srtf_pkg::entry_t    cand;
  logic [7:0]          age_c;
  logic [7:0]          age_b;
  logic                cand_better;
  logic                take_cand;
  srtf_pkg::out_item_t arr_res;
  srtf_pkg::out_item_t dec_res;
  logic                cur_valid;
  logic [7:0]          cur_proc;
  logic [15:0]         cur_left;
  logic [15:0]         left_dec;
  logic                run_valid_nxt;
  logic [15:0]         run_left_nxt;
  logic                oc_bump;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign arrive    = accept && (in_data.func == srtf_pkg::FUNC_ARRIVE);
  assign res_valid = (state_r == ST_RESP);
  assign res_data  = res_r;

  // Compare the returned slot against the best so far
  assign cand  = tbl_rsp.rd_data;
  assign age_c = oc_r - cand.order;
  assign age_b = oc_r - best_r.order;
  always_comb begin
    cand_better = 1'b0;
    if (!found_r) begin
      cand_better = 1'b1;
    end else if (cand.remaining != best_r.remaining) begin
      cand_better = (cand.remaining < best_r.remaining);
    end else if (cand.stamp != best_r.stamp) begin
      cand_better = (cand.stamp < best_r.stamp);
    end else begin
      cand_better = (age_c > age_b);
    end
  end
  assign take_cand = pend_r && tbl_rsp.rd_valid && cand_better;

  // Build the arrival result
  always_comb begin
    arr_res          = '0;
    arr_res.mark     = srtf_pkg::MARK_ARRIVAL;
    arr_res.accepted = !tbl_rsp.full;
  end

  // Decide the tick outcome and drive table requests
  always_comb begin
    tbl_req         = '0;
    tbl_req.rd_en   = (state_r == ST_SCAN) &&
                      (cnt_r < srtf_pkg::CNT_W'(srtf_pkg::TABLE_DEPTH));
    tbl_req.rd_addr = cnt_r[srtf_pkg::IDX_W-1:0];

    dec_res   = '0;
    cur_valid = run_valid_r;
    cur_proc  = run_proc_r;
    cur_left  = run_left_r;
    oc_bump   = 1'b0;

    if (arrive && !tbl_rsp.full) begin
      tbl_req.wr_en             = 1'b1;
      tbl_req.wr_addr           = tbl_rsp.free_idx;
      tbl_req.wr_data.id        = in_data.proc_id;
      tbl_req.wr_data.remaining = in_data.burst;
      tbl_req.wr_data.stamp     = in_data.now;
      tbl_req.wr_data.order     = oc_r;
      tbl_req.wr_data.started   = 1'b0;
      tbl_req.wr_set_valid      = 1'b1;
    end

    if (state_r == ST_DECIDE) begin
      dec_res.mark = srtf_pkg::MARK_IDLE;
      if (!run_valid_r) begin
        // Idle processor: take the best entry out of the table
        if (found_r) begin
          tbl_req.clr_en   = 1'b1;
          tbl_req.clr_addr = best_idx_r;
          cur_valid        = 1'b1;
          cur_proc         = best_r.id;
          cur_left         = best_r.remaining;
          dec_res.mark     = srtf_pkg::MARK_SWITCH;
          if (!best_r.started) begin
            dec_res.first_start = 1'b1;
            dec_res.launch_time = now_r;
          end
        end
      end else if (found_r && (best_r.remaining < run_left_r)) begin
        // Preempt: swap running process into the picked slot
        tbl_req.wr_en             = 1'b1;
        tbl_req.wr_addr           = best_idx_r;
        tbl_req.wr_data.id        = run_proc_r;
        tbl_req.wr_data.remaining = run_left_r;
        tbl_req.wr_data.stamp     = now_r;
        tbl_req.wr_data.order     = oc_r;
        tbl_req.wr_data.started   = 1'b1;
        oc_bump                   = 1'b1;
        cur_proc                  = best_r.id;
        cur_left                  = best_r.remaining;
        dec_res.mark              = srtf_pkg::MARK_SWITCH;
        if (!best_r.started) begin
          dec_res.first_start = 1'b1;
          dec_res.launch_time = now_r;
        end
      end else begin
        // Keep the running process; requeue the picked entry
        if (found_r) begin
          tbl_req.wr_en         = 1'b1;
          tbl_req.wr_addr       = best_idx_r;
          tbl_req.wr_data       = best_r;
          tbl_req.wr_data.order = oc_r;
          oc_bump               = 1'b1;
        end
        dec_res.mark = srtf_pkg::MARK_CONTINUE;
      end
    end

    // Consume one time unit from the running process
    left_dec      = (cur_left > {8'd0, time_unit}) ? (cur_left - {8'd0, time_unit}) : 16'd0;
    run_valid_nxt = cur_valid;
    run_left_nxt  = cur_left;
    if (cur_valid) begin
      dec_res.run_id = cur_proc;
      run_left_nxt   = left_dec;
      if (left_dec == 16'd0) begin
        dec_res.completed   = 1'b1;
        dec_res.finish_time = now_r + {24'd0, time_unit};
        run_valid_nxt       = 1'b0;
      end
    end
  end

  // Hold state and registered results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      oc_r        <= '0;
      run_valid_r <= 1'b0;
      run_proc_r  <= '0;
      run_left_r  <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      cnt_r       <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            now_r <= in_data.now;
            if (in_data.func == srtf_pkg::FUNC_ARRIVE) begin
              res_r <= arr_res;
              if (!tbl_rsp.full) begin
                oc_r <= oc_r + 8'd1;
              end
              state_r <= ST_RESP;
            end else begin
              cnt_r   <= '0;
              pend_r  <= 1'b0;
              found_r <= 1'b0;
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          pend_r <= tbl_req.rd_en;
          pidx_r <= tbl_req.rd_addr;
          if (tbl_req.rd_en) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (take_cand) begin
            found_r    <= 1'b1;
            best_r     <= cand;
            best_idx_r <= pidx_r;
          end
          if (!tbl_req.rd_en) begin
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          run_valid_r <= run_valid_nxt;
          run_proc_r  <= cur_proc;
          run_left_r  <= run_left_nxt;
          if (oc_bump) begin
            oc_r <= oc_r + 8'd1;
          end
          res_r   <= dec_res;
          state_r <= ST_RESP;
        end
        ST_RESP: begin
          if (res_take) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/srtf_preemptive_scheduler_top.sv =====
// Top level of the SRTF scheduler: config register, output register, controller and table.
//
// Input channel (in_valid / in_stall / in_data) carries arrival and tick transactions.
// Output channel (out_valid / out_stall / out_data) returns exactly one result per input.
// cfg_wr_en / cfg_wr_data write the time_unit register (reset value 1); write it only
// while no transaction is in flight.
// An arrival result is registered in the controller in the accept cycle, then handed
// on to the output register; the lowest free slot is found from the valid bits and
// written in the accept cycle. A tick scans the table: the slot memory is read one slot
// per cycle through its single read port, the last read result is taken in, a decide
// state writes back the preempted or requeued entry or clears the picked one, and a
// response state hands off the result. One transaction is worked on at a time; the
// next is accepted in the cycle after the result moves to the output register, while
// that result may still wait there.
// Synchronous active-low reset clears the valid bits, the running process, the order
// counter and both handshakes; slot contents are left as they are.
// While out_stall is high the result holds in the output register, one more finished
// result holds in the controller, and in_stall stays high until room frees up.
module srtf_preemptive_scheduler_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  srtf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output srtf_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data
);

  logic [7:0]          time_unit_r;
  logic                out_valid_r;
  srtf_pkg::out_item_t out_data_r;
  logic                res_valid;
  srtf_pkg::out_item_t res_data;
  logic                res_take;
  srtf_pkg::tbl_req_t  tbl_req;
  srtf_pkg::tbl_rsp_t  tbl_rsp;

  // Hold the time unit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_unit_r <= 8'd1;
    end else if (cfg_wr_en) begin
      time_unit_r <= cfg_wr_data;
    end
  end

  // Advance the output register when it is empty or being drained
  assign res_take = !out_valid_r || !out_stall;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  srtf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .time_unit (time_unit_r),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_take  (res_take),
    .tbl_req   (tbl_req),
    .tbl_rsp   (tbl_rsp)
  );

  srtf_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tbl_req),
    .rsp   (tbl_rsp)
  );

endmodule

// ===== tb/sv/srtf_schedule_checker.sv =====
`timescale 1ns / 1ps
// Checker that predicts each scheduler result and compares it with the output channel.
module srtf_schedule_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  srtf_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  srtf_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  output int                  fail_count,
  output int                  results_due
);

  // Predicted scheduler state
  logic [7:0]  unit_size;
  logic        wait_valid   [srtf_pkg::TABLE_DEPTH];
  logic [7:0]  wait_pid     [srtf_pkg::TABLE_DEPTH];
  logic [15:0] wait_left    [srtf_pkg::TABLE_DEPTH];
  logic [31:0] wait_stamp   [srtf_pkg::TABLE_DEPTH];
  logic [7:0]  wait_seq     [srtf_pkg::TABLE_DEPTH];
  logic        wait_started [srtf_pkg::TABLE_DEPTH];
  logic [7:0]  seq_ctr;
  logic        cpu_busy;
  logic [7:0]  cpu_pid;
  logic [15:0] cpu_left;

  srtf_pkg::out_item_t pending_results[$];
  int                  result_idx;

  // True when waiting entry a should be picked over waiting entry b
  function automatic bit outranks(input int a, input int b);
    logic [7:0] age_a;
    logic [7:0] age_b;
    if (wait_left[a] != wait_left[b]) return wait_left[a] < wait_left[b];
    if (wait_stamp[a] != wait_stamp[b]) return wait_stamp[a] < wait_stamp[b];
    age_a = seq_ctr - wait_seq[a];
    age_b = seq_ctr - wait_seq[b];
    return age_a > age_b;
  endfunction

  // Advance the predicted state by one transaction and return its result
  function automatic srtf_pkg::out_item_t next_schedule_result(input srtf_pkg::in_item_t item);
    srtf_pkg::out_item_t res;
    int                  pick;
    logic [7:0]          nid;
    logic [15:0]         nleft;
    logic                nstarted;
    res  = '0;
    pick = -1;
    if (item.func == srtf_pkg::FUNC_ARRIVE) begin
      res.mark = srtf_pkg::MARK_ARRIVAL;
      for (int i = 0; i < srtf_pkg::TABLE_DEPTH; i++)
        if (!wait_valid[i] && pick < 0) pick = i;
      if (pick >= 0) begin
        wait_valid[pick]   = 1'b1;
        wait_pid[pick]     = item.proc_id;
        wait_left[pick]    = item.burst;
        wait_stamp[pick]   = item.now;
        wait_seq[pick]     = seq_ctr;
        wait_started[pick] = 1'b0;
        seq_ctr            = seq_ctr + 8'd1;
        res.accepted       = 1'b1;
      end
    end else begin
      res.mark = srtf_pkg::MARK_IDLE;
      for (int i = 0; i < srtf_pkg::TABLE_DEPTH; i++)
        if (wait_valid[i] && (pick < 0 || outranks(i, pick))) pick = i;
      if (!cpu_busy) begin
        // Switch in from an idle processor
        if (pick >= 0) begin
          wait_valid[pick] = 1'b0;
          cpu_pid  = wait_pid[pick];
          cpu_left = wait_left[pick];
          cpu_busy = 1'b1;
          res.mark = srtf_pkg::MARK_SWITCH;
          if (!wait_started[pick]) begin
            res.first_start = 1'b1;
            res.launch_time = item.now;
          end
        end
      end else if (pick >= 0 && wait_left[pick] < cpu_left) begin
        // Preempt: the running process takes the picked slot
        nid      = wait_pid[pick];
        nleft    = wait_left[pick];
        nstarted = wait_started[pick];
        wait_pid[pick]     = cpu_pid;
        wait_left[pick]    = cpu_left;
        wait_stamp[pick]   = item.now;
        wait_seq[pick]     = seq_ctr;
        wait_started[pick] = 1'b1;
        seq_ctr  = seq_ctr + 8'd1;
        cpu_pid  = nid;
        cpu_left = nleft;
        res.mark = srtf_pkg::MARK_SWITCH;
        if (!nstarted) begin
          res.first_start = 1'b1;
          res.launch_time = item.now;
        end
      end else begin
        // Keep the running process; the picked entry is requeued
        if (pick >= 0) begin
          wait_seq[pick] = seq_ctr;
          seq_ctr        = seq_ctr + 8'd1;
        end
        res.mark = srtf_pkg::MARK_CONTINUE;
      end
      if (cpu_busy) begin
        res.run_id = cpu_pid;
        cpu_left   = (cpu_left > 16'(unit_size)) ? cpu_left - 16'(unit_size) : 16'd0;
        if (cpu_left == 16'd0) begin
          res.completed   = 1'b1;
          res.finish_time = item.now + 32'(unit_size);
          cpu_busy        = 1'b0;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH result %0d: %s", result_idx, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got)
      report_mismatch($sformatf("%s expected 'h%0h got 'h%0h", name, want, got));
  endtask

  // Track config, compare finished transactions, predict accepted ones
  always @(posedge clk) begin
    srtf_pkg::out_item_t want;
    if (!rst_n) begin
      unit_size = 8'd1;
      for (int i = 0; i < srtf_pkg::TABLE_DEPTH; i++) begin
        wait_valid[i]   = 1'b0;
        wait_pid[i]     = '0;
        wait_left[i]    = '0;
        wait_stamp[i]   = '0;
        wait_seq[i]     = '0;
        wait_started[i] = 1'b0;
      end
      seq_ctr    = '0;
      cpu_busy   = 1'b0;
      cpu_pid    = '0;
      cpu_left   = '0;
      result_idx = 0;
      fail_count = 0;
      pending_results.delete();
      results_due <= 0;
    end else begin
      if (cfg_wr_en) unit_size = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = pending_results.pop_front();
          check_field("mark", 32'(want.mark), 32'(out_data.mark));
          check_field("accepted", 32'(want.accepted), 32'(out_data.accepted));
          check_field("run_id", 32'(want.run_id), 32'(out_data.run_id));
          check_field("first_start", 32'(want.first_start), 32'(out_data.first_start));
          check_field("launch_time", want.launch_time, out_data.launch_time);
          check_field("completed", 32'(want.completed), 32'(out_data.completed));
          check_field("finish_time", want.finish_time, out_data.finish_time);
        end
        result_idx++;
      end
      if (in_valid && !in_stall) begin
        want = next_schedule_result(in_data);
        pending_results.insert(pending_results.size(), want);
      end
      results_due <= pending_results.size();
    end
  end

endmodule

// ===== tb/sv/srtf_preemptive_scheduler_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top: drives arrivals, ticks and config writes into the scheduler and gives the verdict.
module srtf_preemptive_scheduler_top_tb;

  localparam int CYCLE_LIMIT = 400000;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                in_valid    = 1'b0;
  srtf_pkg::in_item_t  in_data     = '0;
  logic                out_stall   = 1'b0;
  logic                cfg_wr_en   = 1'b0;
  logic [7:0]          cfg_wr_data = 8'd0;
  logic                in_stall;
  logic                out_valid;
  srtf_pkg::out_item_t out_data;

  int          fail_count;
  int          results_due;
  int          gap_pct     = 0;
  int          stall_pct   = 0;
  int          cycle_count = 0;
  logic [31:0] sim_now     = 32'd100;

  int phase_unit  [7] = '{255, 1, 0, 37, 1, 2, 255};
  int phase_items [7] = '{100, 100, 60, 100, 100, 100, 100};

  always #5 clk = ~clk;

  srtf_preemptive_scheduler_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  srtf_schedule_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  // Stall the result channel at the phase's rate
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // End the run if it hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("srtf_preemptive_scheduler_top verification failed");
    $finish;
  end

  // Offer one transaction, after optional idle cycles, and hold it until accepted
  task automatic send_item(input logic f, input logic [7:0] pid, input logic [15:0] burst,
                           input logic [31:0] stamp);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data.func    <= f;
    in_data.proc_id <= pid;
    in_data.burst   <= burst;
    in_data.now     <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold off until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  task automatic write_time_unit(input logic [7:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [15:0] pick_burst();
    int r;
    r = $urandom_range(99);
    if (r < 72) return 16'($urandom_range(1, 12));
    if (r < 93) return 16'($urandom_range(13, 300));
    if (r < 96) return 16'($urandom_range(301, 4000));
    if (r < 99) return 16'd0;
    return 16'hFFFF;
  endfunction

  // Mostly arrival groups followed by ticks, with some fully random transactions
  task automatic random_phase(input int count);
    int sent;
    int n_arr;
    int n_tick;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 90) begin
        n_arr  = $urandom_range(1, 4);
        n_tick = $urandom_range(1, 8);
        repeat (n_arr) begin
          send_item(srtf_pkg::FUNC_ARRIVE, 8'($urandom_range(255)), pick_burst(), sim_now);
          if ($urandom_range(1)) sim_now += 32'd1;
          sent++;
        end
        repeat (n_tick) begin
          send_item(srtf_pkg::FUNC_TICK, 8'($urandom_range(255)), 16'($urandom), sim_now);
          sim_now += 32'($urandom_range(0, 3));
          sent++;
        end
      end else begin
        send_item(1'($urandom_range(1)), 8'($urandom), 16'($urandom), $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: idle tick, ties, first start, preemption, zero burst, full table, wrap
    send_item(srtf_pkg::FUNC_TICK,   8'hA5, 16'h5A5A, 32'd0);
    send_item(srtf_pkg::FUNC_ARRIVE, 8'd0,   16'd5,   32'd0);
    send_item(srtf_pkg::FUNC_ARRIVE, 8'd255, 16'd5,   32'd0);
    send_item(srtf_pkg::FUNC_ARRIVE, 8'd9,   16'd5,   32'd1);
    send_item(srtf_pkg::FUNC_TICK,   8'h00, 16'h0000, 32'd2);
    send_item(srtf_pkg::FUNC_ARRIVE, 8'd17,  16'd1,   32'd3);
    send_item(srtf_pkg::FUNC_TICK,   8'hFF, 16'hFFFF, 32'd3);
    send_item(srtf_pkg::FUNC_TICK,   8'h3C, 16'h1234, 32'd4);
    send_item(srtf_pkg::FUNC_ARRIVE, 8'd33,  16'd0,   32'd5);
    send_item(srtf_pkg::FUNC_TICK,   8'h00, 16'h0000, 32'd5);
    send_item(srtf_pkg::FUNC_ARRIVE, 8'd200, 16'hFFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 13; i++)
      send_item(srtf_pkg::FUNC_ARRIVE, 8'($urandom_range(255)), 16'($urandom_range(1, 40)),
                32'd6 + 32'(i));
    write_time_unit(8'd255);
    send_item(srtf_pkg::FUNC_TICK, 8'h00, 16'h0000, 32'hFFFF_FFF0);
    send_item(srtf_pkg::FUNC_TICK, 8'h00, 16'h0000, 32'hFFFF_FFF8);

    // Random phases over several time units and idle patterns
    for (int p = 0; p < 7; p++) begin
      write_time_unit(8'(phase_unit[p]));
      unique case (p % 4)
        0: begin
          gap_pct   = 0;
          stall_pct <= 0;
        end
        1: begin
          gap_pct   = 54;
          stall_pct <= 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct <= 54;
        end
        default: begin
          gap_pct   = 25;
          stall_pct <= 25;
        end
      endcase
      random_phase(phase_items[p]);
    end

    drain();
    repeat (2 * srtf_pkg::TABLE_DEPTH) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("srtf_preemptive_scheduler_top verification clean");
    end else begin
      $display("srtf_preemptive_scheduler_top verification failed");
    end
    $finish;
  end

endmodule
